>>> design/qrv_pkg.sv
// Shared constants for the quaternion vector rotation pipeline.
package qrv_pkg;

    localparam int QUAT_W = 16;
    localparam int N_AXES = 3;
    localparam int N_QUAT = 4;

    typedef logic signed [QUAT_W-1:0] quat_part_t;

endpackage

>>> design/quaternion_rotate_vector.sv
// Quaternion rotation of a 3D vector: q * (0,v) * conj(q), rounded and saturated.
//
//  channel  | group      | payload (lowest bit up)                          | flow
//  ---------+------------+--------------------------------------------------+-----
//  input    | s_axis_*   | quat_w, quat_x, quat_y, quat_z, vec_x, vec_y,    | in
//           |            | vec_z, zero pad to whole bytes                   |
//  result   | m_axis_*   | tdata: rot_x, rot_y, rot_z, zero pad;            | out
//           |            | tuser: clipped                                   |
//
// Six register stages; one transfer per cycle in and out while the output is not
// stalled. The depth is set by the two multiply layers (16 x VECTOR_WIDTH, then
// the 42-bit partial product by 16), each followed by an adder layer, plus the
// input and rounding stages.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stage loads whenever it is empty or its content moves on, so bubbles are
// squeezed out and a stall at the output backs up stage by stage, losing and
// repeating nothing.
module quaternion_rotate_vector
    import qrv_pkg::*;
#(
    parameter int VECTOR_WIDTH       = 24,
    parameter int QUAT_FRACTION_BITS = 14,
    localparam int IN_W  = ((N_QUAT * QUAT_W + N_AXES * VECTOR_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((N_AXES * VECTOR_WIDTH + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, zero pad
    input  logic [IN_W-1:0]      s_axis_tdata,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rot_x, rot_y, rot_z, zero pad
    output logic [OUT_W-1:0]     m_axis_tdata,
    // clipped
    output logic                 m_axis_tuser
);

    localparam int VW     = VECTOR_WIDTH;
    localparam int NSTG   = 6;

    // exact widths of every intermediate
    localparam int M1_W   = QUAT_W + VW;           // quat part times vector part
    localparam int P_W    = M1_W + 2;              // sum of three such products
    localparam int M2_W   = P_W + QUAT_W;          // partial product times quat part
    localparam int R_W    = M2_W + 2;              // sum of four such products
    localparam int SHIFT  = 2 * QUAT_FRACTION_BITS;
    localparam int EXT_W  = (R_W > SHIFT + 1) ? R_W + 1 : SHIFT + 2;
    localparam int SH_W   = EXT_W - SHIFT;
    localparam int CMP_W  = ((SH_W > VW) ? SH_W : VW) + 1;

    localparam logic signed [EXT_W-1:0] HALF   = EXT_W'(1) <<< (SHIFT - 1);
    localparam logic signed [CMP_W-1:0] SAT_HI = (CMP_W'(1) <<< (VW - 1)) - CMP_W'(1);
    localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI - CMP_W'(1);

    // ------------------------------------------------------------------
    // Stage control: valid bits and per-stage load enables
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] vld_in;

    always_comb
    begin
        // walk from the output back: a stage loads when empty or draining
        load[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load[k] = !vld_reg[k] || load[k+1];
        end
        vld_in = {vld_reg[NSTG-2:0], s_axis_tvalid};
        for (int k = 0; k < NSTG; k++)
        begin
            vld_next[k] = load[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = load[0];

    // ------------------------------------------------------------------
    // Stage 1: register the input transfer
    // ------------------------------------------------------------------
    quat_part_t              q1_reg [N_QUAT];
    logic signed [VW-1:0]    v1_reg [N_AXES];

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int i = 0; i < N_QUAT; i++)
            begin
                q1_reg[i] <= s_axis_tdata[i*QUAT_W +: QUAT_W];
            end
            for (int i = 0; i < N_AXES; i++)
            begin
                v1_reg[i] <= s_axis_tdata[N_QUAT*QUAT_W + i*VW +: VW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the twelve products of q * (0, v)
    // q index: 0 = w, 1 = x, 2 = y, 3 = z; v index: 0 = x, 1 = y, 2 = z
    // ------------------------------------------------------------------
    logic signed [M1_W-1:0]  a_next [12];
    logic signed [M1_W-1:0]  a_reg  [12];
    quat_part_t              q2_reg [N_QUAT];

    always_comb
    begin
        a_next[0]  = M1_W'(q1_reg[1]) * M1_W'(v1_reg[0]);   // x*vx
        a_next[1]  = M1_W'(q1_reg[2]) * M1_W'(v1_reg[1]);   // y*vy
        a_next[2]  = M1_W'(q1_reg[3]) * M1_W'(v1_reg[2]);   // z*vz
        a_next[3]  = M1_W'(q1_reg[0]) * M1_W'(v1_reg[0]);   // w*vx
        a_next[4]  = M1_W'(q1_reg[2]) * M1_W'(v1_reg[2]);   // y*vz
        a_next[5]  = M1_W'(q1_reg[3]) * M1_W'(v1_reg[1]);   // z*vy
        a_next[6]  = M1_W'(q1_reg[0]) * M1_W'(v1_reg[1]);   // w*vy
        a_next[7]  = M1_W'(q1_reg[1]) * M1_W'(v1_reg[2]);   // x*vz
        a_next[8]  = M1_W'(q1_reg[3]) * M1_W'(v1_reg[0]);   // z*vx
        a_next[9]  = M1_W'(q1_reg[0]) * M1_W'(v1_reg[2]);   // w*vz
        a_next[10] = M1_W'(q1_reg[1]) * M1_W'(v1_reg[1]);   // x*vy
        a_next[11] = M1_W'(q1_reg[2]) * M1_W'(v1_reg[0]);   // y*vx
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            a_reg  <= a_next;
            q2_reg <= q1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: p = q * (0, v), all four parts
    // ------------------------------------------------------------------
    logic signed [P_W-1:0]   p_next [N_QUAT];
    logic signed [P_W-1:0]   p_reg  [N_QUAT];
    quat_part_t              q3_reg [N_QUAT];

    always_comb
    begin
        p_next[0] = -(P_W'(a_reg[0]) + P_W'(a_reg[1]) + P_W'(a_reg[2]));
        p_next[1] = P_W'(a_reg[3]) + P_W'(a_reg[4])  - P_W'(a_reg[5]);
        p_next[2] = P_W'(a_reg[6]) - P_W'(a_reg[7])  + P_W'(a_reg[8]);
        p_next[3] = P_W'(a_reg[9]) + P_W'(a_reg[10]) - P_W'(a_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            p_reg  <= p_next;
            q3_reg <= q2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the twelve products of p * conj(q), vector parts only
    // ------------------------------------------------------------------
    logic signed [M2_W-1:0]  b_next [12];
    logic signed [M2_W-1:0]  b_reg  [12];

    always_comb
    begin
        // r1 terms: p0*x, p1*w, p2*z, p3*y
        b_next[0]  = M2_W'(p_reg[0]) * M2_W'(q3_reg[1]);
        b_next[1]  = M2_W'(p_reg[1]) * M2_W'(q3_reg[0]);
        b_next[2]  = M2_W'(p_reg[2]) * M2_W'(q3_reg[3]);
        b_next[3]  = M2_W'(p_reg[3]) * M2_W'(q3_reg[2]);
        // r2 terms: p0*y, p1*z, p2*w, p3*x
        b_next[4]  = M2_W'(p_reg[0]) * M2_W'(q3_reg[2]);
        b_next[5]  = M2_W'(p_reg[1]) * M2_W'(q3_reg[3]);
        b_next[6]  = M2_W'(p_reg[2]) * M2_W'(q3_reg[0]);
        b_next[7]  = M2_W'(p_reg[3]) * M2_W'(q3_reg[1]);
        // r3 terms: p0*z, p1*y, p2*x, p3*w
        b_next[8]  = M2_W'(p_reg[0]) * M2_W'(q3_reg[3]);
        b_next[9]  = M2_W'(p_reg[1]) * M2_W'(q3_reg[2]);
        b_next[10] = M2_W'(p_reg[2]) * M2_W'(q3_reg[1]);
        b_next[11] = M2_W'(p_reg[3]) * M2_W'(q3_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            b_reg <= b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: full-precision rotated parts
    // ------------------------------------------------------------------
    logic signed [R_W-1:0]   r_next [N_AXES];
    logic signed [R_W-1:0]   r_reg  [N_AXES];

    always_comb
    begin
        r_next[0] = -R_W'(b_reg[0]) + R_W'(b_reg[1])  - R_W'(b_reg[2])  + R_W'(b_reg[3]);
        r_next[1] = -R_W'(b_reg[4]) + R_W'(b_reg[5])  + R_W'(b_reg[6])  - R_W'(b_reg[7]);
        r_next[2] = -R_W'(b_reg[8]) - R_W'(b_reg[9])  + R_W'(b_reg[10]) + R_W'(b_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            r_reg <= r_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round half up, drop the fraction, saturate
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0] rnd      [N_AXES];
    logic signed [SH_W-1:0]  shifted  [N_AXES];
    logic signed [CMP_W-1:0] wide     [N_AXES];
    logic signed [VW-1:0]    rot_next [N_AXES];
    logic signed [VW-1:0]    rot_reg  [N_AXES];
    logic [N_AXES-1:0]       sat;
    logic                    clip_reg;

    always_comb
    begin
        for (int i = 0; i < N_AXES; i++)
        begin
            rnd[i]     = EXT_W'(r_reg[i]) + HALF;
            shifted[i] = rnd[i][EXT_W-1:SHIFT];
            wide[i]    = CMP_W'(shifted[i]);
            sat[i]     = 1'b0;
            if (wide[i] > SAT_HI)
            begin
                rot_next[i] = SAT_HI[VW-1:0];
                sat[i]      = 1'b1;
            end
            else if (wide[i] < SAT_LO)
            begin
                rot_next[i] = SAT_LO[VW-1:0];
                sat[i]      = 1'b1;
            end
            else
            begin
                rot_next[i] = wide[i][VW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            rot_reg  <= rot_next;
            clip_reg <= |sat;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tuser  = clip_reg;

    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < N_AXES; i++)
        begin
            m_axis_tdata[i*VW +: VW] = rot_reg[i];
        end
    end

`ifndef SYNTHESIS
    // an accepted transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transfer not held in first stage");

    // an empty first stage never refuses input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> s_axis_tready)
        else $error("input refused with empty first stage");

    // a clip flag comes with at least one part pinned to a rail
    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (rot_reg[0] == SAT_HI[VW-1:0]) || (rot_reg[0] == SAT_LO[VW-1:0]) ||
            (rot_reg[1] == SAT_HI[VW-1:0]) || (rot_reg[1] == SAT_LO[VW-1:0]) ||
            (rot_reg[2] == SAT_HI[VW-1:0]) || (rot_reg[2] == SAT_LO[VW-1:0]))
        else $error("clipped set with no saturated part");

    // a held result stays valid until taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-1] && !m_axis_tready |=> vld_reg[NSTG-1])
        else $error("result dropped while stalled");
`endif

endmodule

>>> tb/tb_quaternion_rotate_vector.sv
// Self-checking testbench for the quaternion vector rotation pipeline.
module tb_quaternion_rotate_vector;
    import qrv_pkg::*;

    localparam int VEC_W       = 24;
    localparam int FRAC_BITS   = 14;
    localparam int IN_BITS     = N_QUAT * QUAT_W + N_AXES * VEC_W;
    localparam int OUT_BITS    = N_AXES * VEC_W;
    localparam int LATENCY     = 6;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // One input transfer; the first member is the top of the word, so the
    // layout from bit 0 up is qw, qx, qy, qz, vx, vy, vz.
    typedef struct packed {
        logic signed [VEC_W-1:0] vz;
        logic signed [VEC_W-1:0] vy;
        logic signed [VEC_W-1:0] vx;
        quat_part_t              qz;
        quat_part_t              qy;
        quat_part_t              qx;
        quat_part_t              qw;
    } rot_request_t;

    // Rotated vector as it travels on tdata: x, y, z from bit 0 up.
    typedef struct packed {
        logic signed [VEC_W-1:0] z;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] x;
    } rot_vector_t;

    typedef struct packed {
        logic        clipped;
        rot_vector_t v;
    } rot_result_t;

    // Holds the rotations still owed by the block, oldest first.
    class rotation_scoreboard;
        rot_result_t owed_rotations[$];
        int          failures;
        int          results_seen;

        function new();
            failures     = 0;
            results_seen = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endfunction

        function int outstanding();
            return owed_rotations.size();
        endfunction

        // Divide by 2^(2*FRAC_BITS) rounding half up, then clamp to VEC_W bits.
        function logic signed [VEC_W-1:0] round_clamp(longint acc, ref logic clip);
            longint half;
            longint hi;
            longint lo;
            longint r;
            half = 64'sd1 <<< (2 * FRAC_BITS - 1);
            hi   = (64'sd1 <<< (VEC_W - 1)) - 1;
            lo   = -hi - 1;
            r    = (acc + half) >>> (2 * FRAC_BITS);
            if (r > hi)
            begin
                r    = hi;
                clip = 1'b1;
            end
            if (r < lo)
            begin
                r    = lo;
                clip = 1'b1;
            end
            return r[VEC_W-1:0];
        endfunction

        // Form q * (0,v) * conj(q) exactly; the largest sum is about 60 bits.
        function rot_result_t rotate(rot_request_t rq);
            longint w, x, y, z, vx, vy, vz;
            longint p0, p1, p2, p3;
            longint r1, r2, r3;
            rot_result_t res;
            logic clip;
            w  = $signed(rq.qw);
            x  = $signed(rq.qx);
            y  = $signed(rq.qy);
            z  = $signed(rq.qz);
            vx = $signed(rq.vx);
            vy = $signed(rq.vy);
            vz = $signed(rq.vz);
            // left product with the pure vector
            p0 = -x * vx - y * vy - z * vz;
            p1 =  w * vx + y * vz - z * vy;
            p2 =  w * vy - x * vz + z * vx;
            p3 =  w * vz + x * vy - y * vx;
            // right product with the conjugate; the scalar part is dropped
            r1 = -p0 * x + p1 * w - p2 * z + p3 * y;
            r2 = -p0 * y + p1 * z + p2 * w - p3 * x;
            r3 = -p0 * z - p1 * y + p2 * x + p3 * w;
            clip        = 1'b0;
            res.v.x     = round_clamp(r1, clip);
            res.v.y     = round_clamp(r2, clip);
            res.v.z     = round_clamp(r3, clip);
            res.clipped = clip;
            return res;
        endfunction

        function void note_input(rot_request_t rq);
            owed_rotations.push_back(rotate(rq));
        endfunction

        function void check_result(rot_vector_t got, logic got_clip);
            rot_result_t exp_r;
            results_seen++;
            if (owed_rotations.size() == 0)
            begin
                flag($sformatf("result %0d arrived with nothing owed: x=%0d y=%0d z=%0d clipped=%0b",
                               results_seen, got.x, got.y, got.z, got_clip));
                return;
            end
            exp_r = owed_rotations.pop_front();
            if (got.x !== exp_r.v.x || got.y !== exp_r.v.y || got.z !== exp_r.v.z ||
                got_clip !== exp_r.clipped)
                flag($sformatf({"result %0d: expected x=%0d y=%0d z=%0d clipped=%0b, ",
                                "got x=%0d y=%0d z=%0d clipped=%0b"},
                               results_seen, exp_r.v.x, exp_r.v.y, exp_r.v.z,
                               exp_r.clipped, got.x, got.y, got.z, got_clip));
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // qw, qx, qy, qz, vx, vy, vz
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // rot_x, rot_y, rot_z
    logic [OUT_BITS-1:0] m_axis_tdata;
    // clipped
    logic                m_axis_tuser;

    // Stimulus phase controls, shared by the driver and the result side.
    bit steady      = 1'b0;  // no idling on either side
    bit burst       = 1'b0;  // sender offers back to back
    bit hold_off_go = 1'b0;  // ask the result side for one long stall

    rotation_scoreboard board = new();

    quaternion_rotate_vector #(
        .VECTOR_WIDTH       (VEC_W),
        .QUAT_FRACTION_BITS (FRAC_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic rot_request_t make_request(int w, int x, int y, int z,
                                                  int vx, int vy, int vz);
        rot_request_t rq;
        rq.qw = w[QUAT_W-1:0];
        rq.qx = x[QUAT_W-1:0];
        rq.qy = y[QUAT_W-1:0];
        rq.qz = z[QUAT_W-1:0];
        rq.vx = vx[VEC_W-1:0];
        rq.vy = vy[VEC_W-1:0];
        rq.vz = vz[VEC_W-1:0];
        return rq;
    endfunction

    // Mix of raw noise (mostly clipping), rotations of modest norm over the
    // full vector range, short vectors where rounding dominates, and
    // half-turns about one axis or the identity.
    function automatic rot_request_t random_request();
        rot_request_t rq;
        int kind;
        int axis;
        int mag;
        kind = $urandom_range(99);
        rq.qw = QUAT_W'($urandom);
        rq.qx = QUAT_W'($urandom);
        rq.qy = QUAT_W'($urandom);
        rq.qz = QUAT_W'($urandom);
        rq.vx = VEC_W'($urandom);
        rq.vy = VEC_W'($urandom);
        rq.vz = VEC_W'($urandom);
        if (kind >= 30 && kind < 90)
        begin
            rq.qw = QUAT_W'(int'($urandom_range(16383)) - 8192);
            rq.qx = QUAT_W'(int'($urandom_range(16383)) - 8192);
            rq.qy = QUAT_W'(int'($urandom_range(16383)) - 8192);
            rq.qz = QUAT_W'(int'($urandom_range(16383)) - 8192);
        end
        if (kind >= 70 && kind < 90)
        begin
            rq.vx = VEC_W'(int'($urandom_range(2047)) - 1024);
            rq.vy = VEC_W'(int'($urandom_range(2047)) - 1024);
            rq.vz = VEC_W'(int'($urandom_range(2047)) - 1024);
        end
        if (kind >= 90)
        begin
            axis = $urandom_range(3);
            mag  = $urandom_range(1) ? 16384 : -16384;
            rq.qw = (axis == 0) ? QUAT_W'(mag) : '0;
            rq.qx = (axis == 1) ? QUAT_W'(mag) : '0;
            rq.qy = (axis == 2) ? QUAT_W'(mag) : '0;
            rq.qz = (axis == 3) ? QUAT_W'(mag) : '0;
        end
        return rq;
    endfunction

    // Offer one item and hold it until the block takes the transfer.
    task automatic offer(rot_request_t rq);
        if (!steady && !burst)
        begin
            while ($urandom_range(99) < 14)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rq;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_input(rq);
    endtask

    // Drop valid and wait until every owed rotation has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result side: check each transfer, then pick the next ready level.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(rot_vector_t'(m_axis_tdata), m_axis_tuser);
            if (hold_off_go)
            begin
                hold_left   = HOLD_CYCLES;
                hold_off_go = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 14);
        end
    end

    // Watchdog: end the run when neither side has moved for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity rotation at the vector extremes
        offer(make_request(16384, 0, 0, 0, 8388607, -8388608, 0));
        offer(make_request(16384, 0, 0, 0, 0, 1, -1));
        // zero quaternion collapses everything
        offer(make_request(0, 0, 0, 0, 8388607, 8388607, 8388607));
        // quaternion extremes, heavily scaled: clamp high and low
        offer(make_request(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607));
        offer(make_request(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608));
        offer(make_request(-32768, 0, 0, 0, 8388607, -8388608, 1));
        offer(make_request(32767, -32768, 32767, -32768, -8388608, 8388607, -8388608));
        offer(make_request(0, -32768, 0, 0, 0, 8388607, 1));
        // scale just above one pushes the top value over the edge
        offer(make_request(16385, 0, 0, 0, 8388607, -8388608, 4096));
        // half-turns about each axis
        offer(make_request(0, 16384, 0, 0, 100, 200, 300));
        offer(make_request(0, 0, 16384, 0, 100, 200, 300));
        offer(make_request(0, 0, 0, 16384, 100, 200, 300));
        offer(make_request(0, 0, 0, -16384, -8388608, 8388607, -1));
        // quarter turn about z
        offer(make_request(11585, 0, 0, 11585, 1000, 0, 0));
        offer(make_request(11585, 0, 0, -11585, 0, -1000, 77));
        // exact halves: +0.5 -> 1, -0.5 -> 0, -1.5 -> -1
        offer(make_request(16, 0, 0, 0, 524288, -524288, -1572864));
        offer(make_request(8192, 0, 0, 0, 2, -2, -6));
        offer(make_request(8192, 0, 0, 0, 1, -1, 3));
        // tiny quaternion, rounding of small fractions
        offer(make_request(1, -1, 1, -1, 8388607, -8388608, 12345));
        offer(make_request(-1, 1, -1, 1, -1, 1, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // long output stall while the sender keeps offering
            if (n == 150)
            begin
                burst       = 1'b1;
                hold_off_go = 1'b1;
            end
            if (n == 230)
                burst = 1'b0;
            if (n == 300)
                drain();
            steady = (n >= 400 && n < 550);
            offer(random_request());
        end

        drain();
        repeat (2 * LATENCY + 4) @(posedge clk);
        if (board.outstanding() != 0)
            board.flag($sformatf("%0d rotations never came back", board.outstanding()));

        if (board.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
